// ===== hw/rtl/tvpf_pkg.sv =====
// shared types, codes and helpers of the typed value packet framer
package tvpf_pkg;

  localparam int unsigned ActionW  = 3;
  localparam int unsigned ValueW   = 32;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned LenW     = 16;
  localparam int unsigned MaxBytes = 5;
  localparam int unsigned CntW     = 3;
  localparam int unsigned CfgIdxW  = 1;

  // action codes
  localparam logic [ActionW-1:0] ActStart = 3'd0;
  localparam logic [ActionW-1:0] ActBool  = 3'd1;
  localparam logic [ActionW-1:0] ActByte  = 3'd2;
  localparam logic [ActionW-1:0] ActShort = 3'd3;
  localparam logic [ActionW-1:0] ActInt   = 3'd4;
  localparam logic [ActionW-1:0] ActFloat = 3'd5;
  localparam logic [ActionW-1:0] ActEnd   = 3'd6;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgHead = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgTail = 1'd1;

  localparam logic [ByteW-1:0] HeadReset = 8'd165;
  localparam logic [ByteW-1:0] TailReset = 8'd90;
  localparam logic [ByteW-1:0] BitOne    = 8'h01;
  localparam logic [ByteW-1:0] ByteMask  = 8'hff;

  // one queued burst of output words
  typedef struct packed {
    logic [MaxBytes-1:0][ByteW-1:0] bytes;
    logic [CntW-1:0]                cnt;
    logic [LenW-1:0]                len;
  } tvpf_job_t;

  function automatic logic [LenW-1:0] sat_add(logic [LenW-1:0] a, logic [CntW-1:0] n);
    logic [LenW:0] s;
    s = {1'b0, a} + (LenW+1)'(n);
    return s[LenW] ? {LenW{1'b1}} : s[LenW-1:0];
  endfunction

endpackage

// ===== hw/rtl/tvpf_if.sv =====
// channel interfaces of the typed value packet framer
interface tvpf_in_if;
  logic                             valid;
  logic                             ready;
  logic [tvpf_pkg::ActionW-1:0]     action;
  logic [tvpf_pkg::ValueW-1:0]      value;
  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

interface tvpf_out_if;
  logic                             valid;
  logic                             ready;
  logic [tvpf_pkg::ByteW-1:0]       out_byte;
  logic                             last;
  logic [tvpf_pkg::LenW-1:0]        packet_length;
  modport source (output valid, output out_byte, output last, output packet_length,
                  input ready);
  modport sink   (input valid, input out_byte, input last, input packet_length,
                  output ready);
endinterface

interface tvpf_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [tvpf_pkg::CfgIdxW-1:0]     index;
  logic [tvpf_pkg::ByteW-1:0]       data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/typed_value_packet_framer_top.sv =====
// top level of the typed value packet framer
//
// usage:
//   in_i  takes one item per handshake: an action (start, bool, byte, short,
//         int, float, end) and a 32-bit raw value
//   out_o delivers the packet as a stream of words, one byte per word; last
//         marks the final word an item causes, packet_length is set on the
//         tail word of an end item and zero elsewhere
//   cfg_i writes head_byte (index 0) and tail_byte (index 1); always ready,
//         write only while the block is idle
// path: the first word of an item is written to a queue entry and then loaded into
//   the back register before it is valid on out_o; a busy back part holds it in the
//   queue until the current burst is done
// throughput: the back part sends one word per cycle while out_o ready is high;
//   an item causes up to five words; the two-entry queue lets the front
//   take new items while a burst is still going out
// reset: head 165, tail 90, all packet state cleared, queue and output empty
// stall: when out_o ready is low the current word holds; once the queue is
//   full in_i ready drops until the back part frees an entry
module typed_value_packet_framer_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  tvpf_in_if.sink    in_i,
  tvpf_out_if.source out_o,
  tvpf_cfg_if.sink   cfg_i
);

  logic                q_push, q_full, q_pop, q_empty;
  tvpf_pkg::tvpf_job_t push_job, pop_job;

  // configuration is always taken
  assign cfg_i.ready = 1'b1;

  // front: ordering rules, bool packing, checksum and length
  tvpf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .action_i    (in_i.action),
    .value_i     (in_i.value),
    .cfg_valid_i (cfg_i.valid),
    .cfg_index_i (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_job_o     (push_job)
  );

  // decouples item intake from word output
  tvpf_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_job_i (push_job),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .pop_job_o  (pop_job),
    .empty_o    (q_empty)
  );

  // back: serializes each burst onto the output channel
  tvpf_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (q_empty),
    .q_job_i         (pop_job),
    .q_pop_o         (q_pop),
    .out_valid_o     (out_o.valid),
    .out_ready_i     (out_o.ready),
    .out_byte_o      (out_o.out_byte),
    .last_o          (out_o.last),
    .packet_length_o (out_o.packet_length)
  );

endmodule

// ===== hw/rtl/tvpf_front.sv =====
// front part: packet state, field ordering and burst building
module tvpf_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [tvpf_pkg::ActionW-1:0]  action_i,
  input  logic [tvpf_pkg::ValueW-1:0]   value_i,
  input  logic                          cfg_valid_i,
  input  logic [tvpf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [tvpf_pkg::ByteW-1:0]    cfg_data_i,
  input  logic                          q_full_i,
  output logic                          q_push_o,
  output tvpf_pkg::tvpf_job_t           q_job_o
);

  logic [tvpf_pkg::ByteW-1:0]   head_q, tail_q;
  logic [tvpf_pkg::ActionW-1:0] stage_q, stage_d;
  logic [2:0]                   bc_q, bc_d;
  logic [tvpf_pkg::ByteW-1:0]   acc_q, acc_d;
  logic [tvpf_pkg::ByteW-1:0]   sum_q, sum_d;
  logic [tvpf_pkg::LenW-1:0]    count_q, count_d;

  logic                         accept;
  logic                         flush;
  logic [tvpf_pkg::ByteW-1:0]   fl_byte, sum_fl, bool_acc, vsum;
  logic [tvpf_pkg::LenW-1:0]    count_fl;
  logic [tvpf_pkg::CntW-1:0]    nb;
  logic [tvpf_pkg::ValueW-1:0]  vmask;
  tvpf_pkg::tvpf_job_t          job;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign q_push_o   = accept && (job.cnt != '0);
  assign q_job_o    = job;

  always_comb begin
    flush    = (bc_q != '0);
    fl_byte  = flush ? acc_q : '0;
    sum_fl   = sum_q + fl_byte;
    count_fl = tvpf_pkg::sat_add(count_q, {2'b00, flush});
    bool_acc = acc_q | ((value_i != '0) ? (tvpf_pkg::BitOne << bc_q) : '0);
    case (action_i)
      tvpf_pkg::ActByte:  nb = 3'd1;
      tvpf_pkg::ActShort: nb = 3'd2;
      default:            nb = 3'd4;
    endcase
    case (nb)
      3'd1:    vmask = {24'h0, value_i[7:0]};
      3'd2:    vmask = {16'h0, value_i[15:0]};
      default: vmask = value_i;
    endcase
    vsum = vmask[7:0] + vmask[15:8] + vmask[23:16] + vmask[31:24];

    stage_d   = stage_q;
    bc_d      = bc_q;
    acc_d     = acc_q;
    sum_d     = sum_q;
    count_d   = count_q;
    job.bytes = {8'h00, value_i};
    job.cnt   = '0;
    job.len   = '0;

    case (action_i)
      tvpf_pkg::ActStart: begin
        stage_d      = '0;
        bc_d         = '0;
        acc_d        = '0;
        sum_d        = '0;
        count_d      = 16'd1;
        job.bytes[0] = head_q;
        job.cnt      = 3'd1;
      end
      tvpf_pkg::ActBool: begin
        if (stage_q <= tvpf_pkg::ActBool) begin
          stage_d = tvpf_pkg::ActBool;
          if (bc_q == 3'd7) begin
            // eighth bool completes the byte
            job.bytes[0] = bool_acc;
            job.cnt      = 3'd1;
            sum_d        = sum_q + bool_acc;
            count_d      = tvpf_pkg::sat_add(count_q, 3'd1);
            bc_d         = '0;
            acc_d        = '0;
          end else begin
            bc_d  = bc_q + 3'd1;
            acc_d = bool_acc;
          end
        end
      end
      tvpf_pkg::ActByte, tvpf_pkg::ActShort, tvpf_pkg::ActInt, tvpf_pkg::ActFloat: begin
        if (stage_q <= action_i) begin
          job.bytes = flush ? {value_i, acc_q} : {8'h00, value_i};
          job.cnt   = nb + {2'b00, flush};
          sum_d     = sum_fl + vsum;
          count_d   = tvpf_pkg::sat_add(count_q, nb + {2'b00, flush});
          bc_d      = '0;
          acc_d     = '0;
          stage_d   = action_i;
        end
      end
      tvpf_pkg::ActEnd: begin
        job.bytes = flush ? {16'h0, tail_q, sum_fl, acc_q} : {24'h0, tail_q, sum_q};
        job.cnt   = flush ? 3'd3 : 3'd2;
        job.len   = tvpf_pkg::sat_add(count_fl, 3'd2);
        sum_d     = sum_fl;
        count_d   = count_fl;
        bc_d      = '0;
        acc_d     = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= tvpf_pkg::HeadReset;
      tail_q  <= tvpf_pkg::TailReset;
      stage_q <= '0;
      bc_q    <= '0;
      acc_q   <= '0;
      sum_q   <= '0;
      count_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          tvpf_pkg::CfgHead: head_q <= cfg_data_i & tvpf_pkg::ByteMask;
          tvpf_pkg::CfgTail: tail_q <= cfg_data_i & tvpf_pkg::ByteMask;
          default: begin
          end
        endcase
      end
      if (accept) begin
        stage_q <= stage_d;
        bc_q    <= bc_d;
        acc_q   <= acc_d;
        sum_q   <= sum_d;
        count_q <= count_d;
      end
    end
  end

endmodule

// ===== hw/rtl/tvpf_queue.sv =====
// two-entry burst queue between front and back
module tvpf_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  tvpf_pkg::tvpf_job_t  push_job_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output tvpf_pkg::tvpf_job_t  pop_job_o,
  output logic                 empty_o
);

  tvpf_pkg::tvpf_job_t mem_q [2];
  logic                wp_q, rp_q;
  logic [1:0]          fill_q;

  assign full_o    = (fill_q == 2'd2);
  assign empty_o   = (fill_q == 2'd0);
  assign pop_job_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= 1'b0;
      rp_q   <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      if (push_i) begin
        wp_q <= !wp_q;
      end
      if (pop_i) begin
        rp_q <= !rp_q;
      end
      case ({push_i, pop_i})
        2'b10:   fill_q <= fill_q + 2'd1;
        2'b01:   fill_q <= fill_q - 2'd1;
        default: fill_q <= fill_q;
      endcase
    end
  end

endmodule

// ===== hw/rtl/tvpf_back.sv =====
// back part: sends each queued burst one word per cycle while out_ready_i is high
module tvpf_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_empty_i,
  input  tvpf_pkg::tvpf_job_t           q_job_i,
  output logic                          q_pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [tvpf_pkg::ByteW-1:0]    out_byte_o,
  output logic                          last_o,
  output logic [tvpf_pkg::LenW-1:0]     packet_length_o
);

  tvpf_pkg::tvpf_job_t        job_q;
  logic                       valid_q;
  logic [tvpf_pkg::CntW-1:0]  idx_q;
  logic                       is_last, done, load;

  assign is_last         = (idx_q == job_q.cnt - 3'd1);
  assign done            = valid_q && out_ready_i && is_last;
  assign load            = (!valid_q || done) && !q_empty_i;
  assign q_pop_o         = load;
  assign out_valid_o     = valid_q;
  assign out_byte_o      = job_q.bytes[idx_q];
  assign last_o          = is_last;
  assign packet_length_o = is_last ? job_q.len : '0;

  always_ff @(posedge clk_i) begin
    if (load) begin
      job_q <= q_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= '0;
      end else if (done) begin
        valid_q <= 1'b0;
        idx_q   <= '0;
      end else if (valid_q && out_ready_i) begin
        idx_q <= idx_q + 3'd1;
      end
    end
  end

endmodule
